// ===== src/acs_pkg.sv =====
package acs_pkg;

	localparam int HOUR_W = 5;
	localparam int MINUTE_W = 6;
	localparam int CFG_W = 8;
	localparam int CFG_IDX_W = 1;
	localparam int MODE_W = 3;
	localparam int NUM_BTN = 3;

	localparam logic [HOUR_W-1:0] HOURS_PER_DAY = HOUR_W'(24);
	localparam logic [MINUTE_W-1:0] MINUTES_PER_HOUR = MINUTE_W'(60);
	localparam logic [CFG_W-1:0] REFRESH_PERIOD_RST = CFG_W'(6);
	localparam logic [CFG_W-1:0] REPEAT_DELAY_RST = CFG_W'(12);

	localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = CFG_IDX_W'(1);

	localparam logic [MODE_W-1:0] MODE_SHOW_TIME = 3'd0;
	localparam logic [MODE_W-1:0] MODE_EDIT_TIME_HOUR = 3'd1;
	localparam logic [MODE_W-1:0] MODE_EDIT_TIME_MIN = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SHOW_ALARM = 3'd3;
	localparam logic [MODE_W-1:0] MODE_EDIT_ALARM_HOUR = 3'd4;
	localparam logic [MODE_W-1:0] MODE_EDIT_ALARM_MIN = 3'd5;

	localparam int BTN_INC = 0;
	localparam int BTN_VIEW = 1;
	localparam int BTN_FIELD = 2;

	typedef struct packed {
		logic frame_tick;
		logic btn_increment;
		logic btn_view_toggle;
		logic btn_field_select;
		logic alarm_switch;
		logic [HOUR_W-1:0] clock_hour;
		logic [MINUTE_W-1:0] clock_minute;
	} item_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CFG_W-1:0] refresh_count;
		logic blink_phase;
		logic [HOUR_W-1:0] alm_hr;
		logic [MINUTE_W-1:0] alm_min;
		logic music_on;
	} state_t;

	typedef struct packed {
		logic refresh;
		logic show_alarm;
		logic blank_hours;
		logic blank_minutes;
		logic set_time;
		logic [HOUR_W-1:0] set_hour;
		logic [MINUTE_W-1:0] set_minute;
		logic [HOUR_W-1:0] alarm_hour_out;
		logic [MINUTE_W-1:0] alarm_minute_out;
		logic music_start;
		logic music_stop;
	} result_t;

endpackage

// ===== src/acs_hold.sv =====
module acs_hold (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     pressed,
	input  logic                     auto_repeat,
	input  logic [acs_pkg::CFG_W-1:0] delay,
	output logic                     act
);

	logic [acs_pkg::CFG_W-1:0] count_q;

	assign act = pressed && ((count_q == delay) || (auto_repeat && (count_q == '0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			if (!pressed) begin
				count_q <= delay;
			end else if (count_q != '0) begin
				count_q <= count_q - acs_pkg::CFG_W'(1);
			end
		end
	end

endmodule

// ===== src/acs_frame.sv =====
module acs_frame (
	input  acs_pkg::item_t                   item,
	input  acs_pkg::state_t                  cur,
	input  logic [acs_pkg::CFG_W-1:0]        refresh_period,
	input  logic [acs_pkg::NUM_BTN-1:0]      act,
	output acs_pkg::state_t                  nxt,
	output acs_pkg::result_t                 res
);

	logic [acs_pkg::CFG_W-1:0] rc_inc;
	logic [acs_pkg::HOUR_W:0] hour_inc;
	logic [acs_pkg::MINUTE_W:0] minute_inc;
	logic [acs_pkg::HOUR_W-1:0] hour_wrap;
	logic [acs_pkg::MINUTE_W-1:0] minute_wrap;
	logic [acs_pkg::HOUR_W-1:0] ahour_wrap;
	logic [acs_pkg::MINUTE_W-1:0] amin_wrap;
	logic [acs_pkg::MODE_W-1:0] m0;
	logic [acs_pkg::MODE_W-1:0] m1;
	logic [acs_pkg::HOUR_W-1:0] eh;
	logic [acs_pkg::MINUTE_W-1:0] em;
	logic edit_mode;

	always_comb begin
		m0 = cur.mode;
		rc_inc = cur.refresh_count + acs_pkg::CFG_W'(1);
		hour_inc = {1'b0, item.clock_hour} + (acs_pkg::HOUR_W+1)'(1);
		minute_inc = {1'b0, item.clock_minute} + (acs_pkg::MINUTE_W+1)'(1);
		hour_wrap = (hour_inc >= {1'b0, acs_pkg::HOURS_PER_DAY}) ? '0
			: hour_inc[acs_pkg::HOUR_W-1:0];
		minute_wrap = (minute_inc >= {1'b0, acs_pkg::MINUTES_PER_HOUR}) ? '0
			: minute_inc[acs_pkg::MINUTE_W-1:0];
		ahour_wrap = (cur.alm_hr + acs_pkg::HOUR_W'(1) >= acs_pkg::HOURS_PER_DAY) ? '0
			: cur.alm_hr + acs_pkg::HOUR_W'(1);
		amin_wrap = (cur.alm_min + acs_pkg::MINUTE_W'(1) >= acs_pkg::MINUTES_PER_HOUR)
			? '0 : cur.alm_min + acs_pkg::MINUTE_W'(1);
		edit_mode = (m0 == acs_pkg::MODE_EDIT_TIME_HOUR) || (m0 == acs_pkg::MODE_EDIT_TIME_MIN)
			|| (m0 == acs_pkg::MODE_EDIT_ALARM_HOUR) || (m0 == acs_pkg::MODE_EDIT_ALARM_MIN);

		nxt = cur;
		res = '0;

		// periodic refresh and blink
		if (rc_inc >= refresh_period) begin
			res.refresh = 1'b1;
			res.show_alarm = (m0 > acs_pkg::MODE_EDIT_TIME_MIN);
			if (cur.blink_phase) begin
				res.blank_hours = (m0 == acs_pkg::MODE_EDIT_TIME_HOUR)
					|| (m0 == acs_pkg::MODE_EDIT_ALARM_HOUR);
				res.blank_minutes = (m0 == acs_pkg::MODE_EDIT_TIME_MIN)
					|| (m0 == acs_pkg::MODE_EDIT_ALARM_MIN);
			end
			nxt.blink_phase = !cur.blink_phase;
			nxt.refresh_count = '0;
		end else begin
			nxt.refresh_count = rc_inc;
		end

		// increment
		if (act[acs_pkg::BTN_INC]) begin
			if (m0 == acs_pkg::MODE_EDIT_TIME_HOUR) begin
				res.set_hour = hour_wrap;
				res.set_minute = item.clock_minute;
				res.set_time = 1'b1;
			end else if (m0 == acs_pkg::MODE_EDIT_TIME_MIN) begin
				res.set_hour = item.clock_hour;
				res.set_minute = minute_wrap;
				res.set_time = 1'b1;
			end else if (m0 == acs_pkg::MODE_EDIT_ALARM_HOUR) begin
				nxt.alm_hr = ahour_wrap;
			end else if (m0 == acs_pkg::MODE_EDIT_ALARM_MIN) begin
				nxt.alm_min = amin_wrap;
			end
			if (edit_mode) begin
				res.refresh = 1'b1;
				res.show_alarm = (m0 >= acs_pkg::MODE_EDIT_ALARM_HOUR);
				res.blank_hours = 1'b0;
				res.blank_minutes = 1'b0;
			end
		end

		// view toggle
		m1 = m0;
		if (act[acs_pkg::BTN_VIEW]) begin
			m1 = (m0 == acs_pkg::MODE_SHOW_TIME) ? acs_pkg::MODE_SHOW_ALARM
				: acs_pkg::MODE_SHOW_TIME;
			res.refresh = 1'b1;
			res.show_alarm = (m1 == acs_pkg::MODE_SHOW_ALARM);
			res.blank_hours = 1'b0;
			res.blank_minutes = 1'b0;
		end

		// field select
		nxt.mode = m1;
		if (act[acs_pkg::BTN_FIELD]) begin
			if (m1 == acs_pkg::MODE_SHOW_TIME) nxt.mode = acs_pkg::MODE_EDIT_TIME_HOUR;
			else if (m1 == acs_pkg::MODE_EDIT_TIME_HOUR) nxt.mode = acs_pkg::MODE_EDIT_TIME_MIN;
			else if (m1 == acs_pkg::MODE_EDIT_TIME_MIN) nxt.mode = acs_pkg::MODE_SHOW_TIME;
			else if (m1 == acs_pkg::MODE_SHOW_ALARM) nxt.mode = acs_pkg::MODE_EDIT_ALARM_HOUR;
			else if (m1 == acs_pkg::MODE_EDIT_ALARM_HOUR) nxt.mode = acs_pkg::MODE_EDIT_ALARM_MIN;
			else if (m1 == acs_pkg::MODE_EDIT_ALARM_MIN) nxt.mode = acs_pkg::MODE_SHOW_ALARM;
		end

		// alarm
		eh = res.set_time ? res.set_hour : item.clock_hour;
		em = res.set_time ? res.set_minute : item.clock_minute;
		if (item.alarm_switch) begin
			if (!cur.music_on && (eh == nxt.alm_hr) && (em == nxt.alm_min)) begin
				res.music_start = 1'b1;
				nxt.music_on = 1'b1;
			end
		end else if (cur.music_on) begin
			res.music_stop = 1'b1;
			nxt.music_on = 1'b0;
		end

		if (!item.frame_tick) begin
			nxt = cur;
			res = '0;
		end
		res.alarm_hour_out = nxt.alm_hr;
		res.alarm_minute_out = nxt.alm_min;
	end

endmodule

// ===== src/alarm_clock_set_controller_core.sv =====
// Alarm clock set controller.
// Input channel: in_valid/in_stall with one frame item (tick, button and
// switch levels, running clock hour and minute). An item is taken at a
// clock edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with one result item per input item:
// display refresh and blanking, clock load command, stored alarm time and
// music start/stop pulses.
// Config channel: cfg_valid/cfg_ready/cfg_index/cfg_data; index 0 is the
// refresh period, index 1 the auto-repeat delay. cfg_ready is always high.
// An item passes one input register, one frame of logic and one result
// register; out_valid rises as the item moves from the input register into
// the result register. Throughput is one item per cycle while out_stall is
// low; the state register updates on the edge that loads the result.
// With out_valid and out_stall high the result register holds and the input
// register still takes one more item; in_stall rises only when both are full.
// Reset clears mode, counters, alarm time and music flag, empties both
// stages, and loads the register defaults (period 6, delay 12).
module alarm_clock_set_controller_core (
	input  logic                             clk,
	input  logic                             arst_n,

	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             frame_tick,
	input  logic                             btn_increment,
	input  logic                             btn_view_toggle,
	input  logic                             btn_field_select,
	input  logic                             alarm_switch,
	input  logic [acs_pkg::HOUR_W-1:0]       clock_hour,
	input  logic [acs_pkg::MINUTE_W-1:0]     clock_minute,

	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             refresh,
	output logic                             show_alarm,
	output logic                             blank_hours,
	output logic                             blank_minutes,
	output logic                             set_time,
	output logic [acs_pkg::HOUR_W-1:0]       set_hour,
	output logic [acs_pkg::MINUTE_W-1:0]     set_minute,
	output logic [acs_pkg::HOUR_W-1:0]       alarm_hour_out,
	output logic [acs_pkg::MINUTE_W-1:0]     alarm_minute_out,
	output logic                             music_start,
	output logic                             music_stop,

	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [acs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [acs_pkg::CFG_W-1:0]        cfg_data
);

	logic [acs_pkg::CFG_W-1:0] refresh_period_q;
	logic [acs_pkg::CFG_W-1:0] repeat_delay_q;

	logic in_valid_s1;
	acs_pkg::item_t item_s1;
	logic out_valid_s2;
	acs_pkg::result_t res_s2;

	acs_pkg::state_t state_q;
	acs_pkg::state_t state_nxt;
	acs_pkg::result_t res;
	logic [acs_pkg::NUM_BTN-1:0] act;
	logic s2_free;
	logic adv;
	logic step_en;
	logic accept;

	assign cfg_ready = 1'b1;
	assign s2_free = !out_valid_s2 || !out_stall;
	assign adv = in_valid_s1 && s2_free;
	assign step_en = adv && item_s1.frame_tick;
	assign in_stall = in_valid_s1 && !s2_free;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_period_q <= acs_pkg::REFRESH_PERIOD_RST;
			repeat_delay_q <= acs_pkg::REPEAT_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				acs_pkg::REG_REFRESH_PERIOD: refresh_period_q <= cfg_data;
				acs_pkg::REG_REPEAT_DELAY: repeat_delay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (accept) begin
			in_valid_s1 <= 1'b1;
		end else if (adv) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{frame_tick: frame_tick, btn_increment: btn_increment,
				btn_view_toggle: btn_view_toggle, btn_field_select: btn_field_select,
				alarm_switch: alarm_switch, clock_hour: clock_hour,
				clock_minute: clock_minute};
		end
	end

	acs_hold u_hold_inc (
		.clk(clk), .arst_n(arst_n), .en(step_en),
		.pressed(item_s1.btn_increment), .auto_repeat(1'b1),
		.delay(repeat_delay_q), .act(act[acs_pkg::BTN_INC])
	);

	acs_hold u_hold_view (
		.clk(clk), .arst_n(arst_n), .en(step_en),
		.pressed(item_s1.btn_view_toggle), .auto_repeat(1'b0),
		.delay(repeat_delay_q), .act(act[acs_pkg::BTN_VIEW])
	);

	acs_hold u_hold_field (
		.clk(clk), .arst_n(arst_n), .en(step_en),
		.pressed(item_s1.btn_field_select), .auto_repeat(1'b0),
		.delay(repeat_delay_q), .act(act[acs_pkg::BTN_FIELD])
	);

	acs_frame u_frame (
		.item(item_s1),
		.cur(state_q),
		.refresh_period(refresh_period_q),
		.act(act),
		.nxt(state_nxt),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= acs_pkg::MODE_SHOW_TIME;
			state_q.refresh_count <= '0;
			state_q.blink_phase <= 1'b1;
			state_q.alm_hr <= '0;
			state_q.alm_min <= '0;
			state_q.music_on <= 1'b0;
		end else if (step_en) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s2_free) begin
			out_valid_s2 <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid = out_valid_s2;
	assign refresh = res_s2.refresh;
	assign show_alarm = res_s2.show_alarm;
	assign blank_hours = res_s2.blank_hours;
	assign blank_minutes = res_s2.blank_minutes;
	assign set_time = res_s2.set_time;
	assign set_hour = res_s2.set_hour;
	assign set_minute = res_s2.set_minute;
	assign alarm_hour_out = res_s2.alarm_hour_out;
	assign alarm_minute_out = res_s2.alarm_minute_out;
	assign music_start = res_s2.music_start;
	assign music_stop = res_s2.music_stop;

endmodule

// ===== tb/tb_alarm_clock_set_controller_core.sv =====
module tb_alarm_clock_set_controller_core;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int FRAMES_PER_CHUNK = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic frame_tick = 1'b0;
	logic btn_increment = 1'b0;
	logic btn_view_toggle = 1'b0;
	logic btn_field_select = 1'b0;
	logic alarm_switch = 1'b0;
	logic [acs_pkg::HOUR_W-1:0] clock_hour = '0;
	logic [acs_pkg::MINUTE_W-1:0] clock_minute = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic refresh;
	logic show_alarm;
	logic blank_hours;
	logic blank_minutes;
	logic set_time;
	logic [acs_pkg::HOUR_W-1:0] set_hour;
	logic [acs_pkg::MINUTE_W-1:0] set_minute;
	logic [acs_pkg::HOUR_W-1:0] alarm_hour_out;
	logic [acs_pkg::MINUTE_W-1:0] alarm_minute_out;
	logic music_start;
	logic music_stop;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [acs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [acs_pkg::CFG_W-1:0] cfg_data = '0;

	alarm_clock_set_controller_core dut (.*);

	// predicted controller state
	logic [acs_pkg::MODE_W-1:0] mode_q;
	logic [acs_pkg::CFG_W-1:0] refresh_cnt_q;
	logic blink_q;
	logic [acs_pkg::CFG_W-1:0] hold_cnt [acs_pkg::NUM_BTN];
	logic [acs_pkg::HOUR_W-1:0] alarm_hr_q;
	logic [acs_pkg::MINUTE_W-1:0] alarm_mn_q;
	logic music_q;
	logic [acs_pkg::CFG_W-1:0] refresh_period_q;
	logic [acs_pkg::CFG_W-1:0] repeat_delay_q;

	acs_pkg::result_t pending_results [$];

	int gap_pct = 34;
	int stall_pct = 77;
	int mismatch_count = 0;
	int frames_sent = 0;
	int results_seen = 0;
	int reg_writes = 0;
	int alarm_starts = 0;
	int clock_loads = 0;
	int quiet_cycles = 0;

	// random button levels
	logic inc_lvl = 1'b0;
	logic view_lvl = 1'b0;
	logic field_lvl = 1'b0;
	logic sw_lvl = 1'b0;
	int toggle_pct = 40;

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic logic button_fires(int idx, logic pressed, logic autorep);
		logic fires;
		fires = 1'b0;
		if (pressed) begin
			fires = (hold_cnt[idx] == repeat_delay_q) || (autorep && hold_cnt[idx] == '0);
			if (hold_cnt[idx] != '0)
				hold_cnt[idx] = hold_cnt[idx] - 1'b1;
		end else begin
			hold_cnt[idx] = repeat_delay_q;
		end
		return fires;
	endfunction

	task automatic predict_frame(input acs_pkg::item_t it, output acs_pkg::result_t r);
		logic [acs_pkg::HOUR_W-1:0] eh;
		logic [acs_pkg::MINUTE_W-1:0] em;
		logic editing;
		r = '0;
		if (it.frame_tick) begin
			refresh_cnt_q = refresh_cnt_q + 1'b1;
			if (refresh_cnt_q >= refresh_period_q) begin
				r.refresh = 1'b1;
				r.show_alarm = (mode_q > acs_pkg::MODE_EDIT_TIME_MIN);
				if (blink_q) begin
					if (mode_q == acs_pkg::MODE_EDIT_TIME_HOUR ||
						mode_q == acs_pkg::MODE_EDIT_ALARM_HOUR)
						r.blank_hours = 1'b1;
					else if (mode_q == acs_pkg::MODE_EDIT_TIME_MIN ||
						mode_q == acs_pkg::MODE_EDIT_ALARM_MIN)
						r.blank_minutes = 1'b1;
					blink_q = 1'b0;
				end else begin
					blink_q = 1'b1;
				end
				refresh_cnt_q = '0;
			end

			if (button_fires(acs_pkg::BTN_INC, it.btn_increment, 1'b1)) begin
				unique case (mode_q)
					acs_pkg::MODE_EDIT_TIME_HOUR: begin
						r.set_hour = (int'(it.clock_hour) + 1 >= int'(acs_pkg::HOURS_PER_DAY)) ?
							'0 : it.clock_hour + 1'b1;
						r.set_minute = it.clock_minute;
						r.set_time = 1'b1;
					end
					acs_pkg::MODE_EDIT_TIME_MIN: begin
						r.set_hour = it.clock_hour;
						r.set_minute =
							(int'(it.clock_minute) + 1 >= int'(acs_pkg::MINUTES_PER_HOUR)) ?
							'0 : it.clock_minute + 1'b1;
						r.set_time = 1'b1;
					end
					acs_pkg::MODE_EDIT_ALARM_HOUR: begin
						alarm_hr_q = (int'(alarm_hr_q) + 1 >= int'(acs_pkg::HOURS_PER_DAY)) ?
							'0 : alarm_hr_q + 1'b1;
					end
					acs_pkg::MODE_EDIT_ALARM_MIN: begin
						alarm_mn_q = (int'(alarm_mn_q) + 1 >= int'(acs_pkg::MINUTES_PER_HOUR)) ?
							'0 : alarm_mn_q + 1'b1;
					end
					default: ;
				endcase
				editing = (mode_q == acs_pkg::MODE_EDIT_TIME_HOUR) ||
					(mode_q == acs_pkg::MODE_EDIT_TIME_MIN) ||
					(mode_q == acs_pkg::MODE_EDIT_ALARM_HOUR) ||
					(mode_q == acs_pkg::MODE_EDIT_ALARM_MIN);
				if (editing) begin
					r.refresh = 1'b1;
					r.show_alarm = (mode_q >= acs_pkg::MODE_EDIT_ALARM_HOUR);
					r.blank_hours = 1'b0;
					r.blank_minutes = 1'b0;
				end
			end

			if (button_fires(acs_pkg::BTN_VIEW, it.btn_view_toggle, 1'b0)) begin
				mode_q = (mode_q == acs_pkg::MODE_SHOW_TIME) ? acs_pkg::MODE_SHOW_ALARM :
					acs_pkg::MODE_SHOW_TIME;
				r.refresh = 1'b1;
				r.show_alarm = (mode_q == acs_pkg::MODE_SHOW_ALARM);
				r.blank_hours = 1'b0;
				r.blank_minutes = 1'b0;
			end

			if (button_fires(acs_pkg::BTN_FIELD, it.btn_field_select, 1'b0)) begin
				unique case (mode_q)
					acs_pkg::MODE_SHOW_TIME: mode_q = acs_pkg::MODE_EDIT_TIME_HOUR;
					acs_pkg::MODE_EDIT_TIME_HOUR: mode_q = acs_pkg::MODE_EDIT_TIME_MIN;
					acs_pkg::MODE_EDIT_TIME_MIN: mode_q = acs_pkg::MODE_SHOW_TIME;
					acs_pkg::MODE_SHOW_ALARM: mode_q = acs_pkg::MODE_EDIT_ALARM_HOUR;
					acs_pkg::MODE_EDIT_ALARM_HOUR: mode_q = acs_pkg::MODE_EDIT_ALARM_MIN;
					acs_pkg::MODE_EDIT_ALARM_MIN: mode_q = acs_pkg::MODE_SHOW_ALARM;
					default: ;
				endcase
			end

			if (it.alarm_switch) begin
				eh = r.set_time ? r.set_hour : it.clock_hour;
				em = r.set_time ? r.set_minute : it.clock_minute;
				if (!music_q && eh == alarm_hr_q && em == alarm_mn_q) begin
					r.music_start = 1'b1;
					music_q = 1'b1;
				end
			end else if (music_q) begin
				r.music_stop = 1'b1;
				music_q = 1'b0;
			end
		end
		r.alarm_hour_out = alarm_hr_q;
		r.alarm_minute_out = alarm_mn_q;
	endtask

	task automatic send_frame(input acs_pkg::item_t it);
		acs_pkg::result_t r;
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		frame_tick <= it.frame_tick;
		btn_increment <= it.btn_increment;
		btn_view_toggle <= it.btn_view_toggle;
		btn_field_select <= it.btn_field_select;
		alarm_switch <= it.alarm_switch;
		clock_hour <= it.clock_hour;
		clock_minute <= it.clock_minute;
		do @(posedge clk); while (in_stall);
		predict_frame(it, r);
		pending_results.push_back(r);
		frames_sent++;
		alarm_starts += r.music_start;
		clock_loads += r.set_time;
	endtask

	task automatic drive_frame(input logic tick, input logic inc, input logic view,
		input logic field, input logic sw, input int hour, input int minute);
		acs_pkg::item_t it;
		it.frame_tick = tick;
		it.btn_increment = inc;
		it.btn_view_toggle = view;
		it.btn_field_select = field;
		it.alarm_switch = sw;
		it.clock_hour = acs_pkg::HOUR_W'(hour);
		it.clock_minute = acs_pkg::MINUTE_W'(minute);
		send_frame(it);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic program_timing(input logic [acs_pkg::CFG_W-1:0] period,
		input logic [acs_pkg::CFG_W-1:0] delay);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= acs_pkg::REG_REFRESH_PERIOD;
		cfg_data <= period;
		do @(posedge clk); while (!cfg_ready);
		refresh_period_q = period;
		cfg_index <= acs_pkg::REG_REPEAT_DELAY;
		cfg_data <= delay;
		do @(posedge clk); while (!cfg_ready);
		repeat_delay_q = delay;
		cfg_valid <= 1'b0;
		reg_writes += 2;
	endtask

	task automatic check_result();
		acs_pkg::result_t got, want;
		logic bad;
		got = '{refresh, show_alarm, blank_hours, blank_minutes, set_time, set_hour,
			set_minute, alarm_hour_out, alarm_minute_out, music_start, music_stop};
		results_seen++;
		if (pending_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("result %0d arrived with nothing expected: %p", results_seen, got);
			return;
		end
		want = pending_results.pop_front();
		bad = (got.refresh !== want.refresh) || (got.show_alarm !== want.show_alarm) ||
			(got.blank_hours !== want.blank_hours) ||
			(got.blank_minutes !== want.blank_minutes) ||
			(got.set_time !== want.set_time) || (got.set_hour !== want.set_hour) ||
			(got.set_minute !== want.set_minute) ||
			(got.alarm_hour_out !== want.alarm_hour_out) ||
			(got.alarm_minute_out !== want.alarm_minute_out) ||
			(got.music_start !== want.music_start) || (got.music_stop !== want.music_stop);
		if (bad) begin
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("result %0d mismatch", results_seen);
				$display("  exp %p", want);
				$display("  got %p", got);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles++;
		end
	end

	function automatic acs_pkg::item_t next_random_frame();
		acs_pkg::item_t it;
		int sel;
		if ($urandom_range(99) < 3)
			toggle_pct = $urandom_range(0, 1) ? 40 : 5;
		if ($urandom_range(99) < toggle_pct) inc_lvl = !inc_lvl;
		if ($urandom_range(99) < toggle_pct) view_lvl = !view_lvl;
		if ($urandom_range(99) < toggle_pct) field_lvl = !field_lvl;
		if ($urandom_range(99) < 4) sw_lvl = !sw_lvl;
		it.frame_tick = ($urandom_range(99) < 92);
		if ($urandom_range(99) < 8) begin
			it.btn_increment = 1'($urandom_range(0, 1));
			it.btn_view_toggle = 1'($urandom_range(0, 1));
			it.btn_field_select = 1'($urandom_range(0, 1));
			it.alarm_switch = 1'($urandom_range(0, 1));
		end else begin
			it.btn_increment = inc_lvl;
			it.btn_view_toggle = view_lvl;
			it.btn_field_select = field_lvl;
			it.alarm_switch = sw_lvl;
		end
		sel = $urandom_range(0, 9);
		it.clock_hour = acs_pkg::HOUR_W'($urandom_range(0, int'(acs_pkg::HOURS_PER_DAY) - 1));
		it.clock_minute =
			acs_pkg::MINUTE_W'($urandom_range(0, int'(acs_pkg::MINUTES_PER_HOUR) - 1));
		unique case (sel)
			0, 1, 2: begin
				it.clock_hour = alarm_hr_q;
				it.clock_minute = alarm_mn_q;
			end
			3: begin
				// one hour short: a load in hour edit lands on the alarm
				it.clock_hour = (alarm_hr_q == '0) ? acs_pkg::HOURS_PER_DAY - 1'b1 :
					alarm_hr_q - 1'b1;
				it.clock_minute = alarm_mn_q;
			end
			4: begin
				it.clock_hour = alarm_hr_q;
				it.clock_minute = (alarm_mn_q == '0) ?
					acs_pkg::MINUTES_PER_HOUR - 1'b1 : alarm_mn_q - 1'b1;
			end
			5: begin
				it.clock_hour = acs_pkg::HOURS_PER_DAY - 1'b1;
				it.clock_minute = acs_pkg::MINUTES_PER_HOUR - 1'b1;
			end
			6: begin
				it.clock_hour = '0;
				it.clock_minute = '0;
			end
			default: ;
		endcase
		return it;
	endfunction

	task automatic test_idle_frames();
		drive_frame(0, 1, 1, 1, 1, 23, 59);
		// buttons held from reset: view and field stay quiet until released
		drive_frame(1, 1, 1, 1, 0, 0, 0);
	endtask

	task automatic test_time_setting();
		drive_frame(1, 0, 0, 0, 0, 12, 30);
		drive_frame(1, 0, 0, 1, 0, 12, 30);
		drive_frame(1, 1, 0, 0, 0, 23, 59);
		drive_frame(1, 0, 0, 1, 0, 23, 59);
		drive_frame(1, 1, 0, 0, 0, 23, 59);
		drive_frame(1, 0, 1, 0, 0, 5, 5);
	endtask

	task automatic test_alarm_setting();
		drive_frame(1, 0, 0, 0, 0, 0, 0);
		drive_frame(1, 0, 1, 0, 0, 0, 0);
		drive_frame(1, 0, 0, 1, 0, 0, 0);
		drive_frame(1, 1, 0, 0, 0, 0, 0);
		drive_frame(1, 0, 0, 1, 0, 0, 0);
		drive_frame(1, 1, 0, 0, 0, 0, 0);
		drive_frame(1, 0, 0, 1, 0, 0, 0);
	endtask

	task automatic test_alarm_music();
		drive_frame(1, 0, 0, 0, 1, 1, 1);
		drive_frame(1, 0, 0, 0, 1, 1, 1);
		drive_frame(1, 0, 0, 0, 0, 1, 1);
		drive_frame(1, 0, 1, 0, 0, 0, 0);
		drive_frame(1, 0, 0, 1, 0, 0, 0);
		// hour load in the same frame hits the alarm time
		drive_frame(1, 1, 0, 0, 1, 0, 1);
	endtask

	task automatic test_zero_registers();
		program_timing('0, '0);
		drive_frame(1, 1, 0, 0, 1, 23, 59);
		drive_frame(1, 1, 0, 0, 0, 23, 59);
		drive_frame(1, 1, 0, 0, 0, 0, 0);
	endtask

	task automatic test_random_frames();
		int profile, chunk, n;
		logic [acs_pkg::CFG_W-1:0] period, delay;
		for (profile = 0; profile < 3; profile++) begin
			unique case (profile)
				0: begin gap_pct = 34; stall_pct = 77; end
				1: begin gap_pct = 77; stall_pct = 34; end
				default: begin gap_pct = 0; stall_pct = 0; end
			endcase
			for (chunk = 0; chunk < 4; chunk++) begin
				unique case (chunk)
					0: begin period = 8'd1; delay = 8'd1; end
					1: begin period = 8'd255; delay = 8'd255; end
					2: begin
						period = acs_pkg::CFG_W'($urandom_range(0, 10));
						delay = acs_pkg::CFG_W'($urandom_range(0, 20));
					end
					default: begin
						period = acs_pkg::REFRESH_PERIOD_RST;
						delay = acs_pkg::REPEAT_DELAY_RST;
					end
				endcase
				program_timing(period, delay);
				for (n = 0; n < FRAMES_PER_CHUNK; n++)
					send_frame(next_random_frame());
			end
		end
	endtask

	initial begin
		mode_q = acs_pkg::MODE_SHOW_TIME;
		refresh_cnt_q = '0;
		blink_q = 1'b1;
		for (int i = 0; i < acs_pkg::NUM_BTN; i++)
			hold_cnt[i] = '0;
		alarm_hr_q = '0;
		alarm_mn_q = '0;
		music_q = 1'b0;
		refresh_period_q = acs_pkg::REFRESH_PERIOD_RST;
		repeat_delay_q = acs_pkg::REPEAT_DELAY_RST;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_frames();
		test_time_setting();
		test_alarm_setting();
		test_alarm_music();
		test_zero_registers();
		test_random_frames();

		drain_results();
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0d expected results never arrived", pending_results.size());
			mismatch_count += pending_results.size();
		end
		$display("%0d frames checked over three handshake profiles, %0d register writes",
			frames_sent, reg_writes);
		$display("%0d clock loads and %0d alarm starts predicted", clock_loads, alarm_starts);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
